/* rtl/midpoint_ellipse_rasterizer_assert.svh */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Shorthand for the clocked implication checks used at the end of the top
// level. Each check is disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define MER_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MER_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/mer_pkg.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Stream widths, operation codes and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package mer_pkg;

   // Field widths on the stream ports
   localparam int SEMI_W     = 10;
   localparam int PIX_W      = 11;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 24;

   // Operation carried in the request tuser
   localparam logic OP_START = 1'b0;
   localparam logic OP_STEP  = 1'b1;

   // Pixel index of the last mirrored pixel of a point
   localparam logic [1:0] PIX_LAST = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_S_A2,
      ST_S_B2,
      ST_S_AB,
      ST_S_FIN,
      ST_R1_LHS,
      ST_R1_RHS,
      ST_R1_CMP,
      ST_R1_INC,
      ST_R1_VERT,
      ST_R2I_BTX,
      ST_R2I_SQ1,
      ST_R2I_ATY,
      ST_R2I_SQ2,
      ST_R2I_AB,
      ST_R2I_SQ3,
      ST_R2I_FIN,
      ST_R2_VERT,
      ST_R2_SUB,
      ST_R2_ADD,
      ST_R2_HOR,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/midpoint_ellipse_rasterizer.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Walks the first quadrant of an origin-centred ellipse with the midpoint
// method and streams the four mirrored pixels of every point.
// ----------------------------------------------------------------------------
// A start word (tuser 0) loads the semi-axes and returns the four pixels of
// (0,b); each step word (tuser 1) advances one point and returns its four
// mirrors in the order (x,y), (x,-y), (-x,y), (-x,-y), tlast on the fourth,
// tuser set on all four pixels of the final point. A step after the curve
// has ended returns nothing. All arithmetic runs through one registered
// multiplier under a sequencer, so the block takes one request at a time:
// each start or step runs its sequencer states and then offers its four
// pixel words, one every cycle while rsp_tready is high. tready is low
// from the accepted request until its last pixel has been taken.
`default_nettype none

`include "midpoint_ellipse_rasterizer_assert.svh"

module midpoint_ellipse_rasterizer #(
   parameter int AXIS_BITS = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [9:0] semi_a, [19:10] semi_b, [23:20] zero
   input  wire logic [mer_pkg::REQ_DATA_W-1:0] req_tdata,
   // [0] op
   input  wire logic                           req_tuser,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [10:0] pix_x, [21:11] pix_y, [23:22] zero
   output logic [mer_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // last_of_group
   output logic                                rsp_tlast,
   // [0] curve_done
   output logic                                rsp_tuser
);
   import mer_pkg::*;

   localparam int N     = AXIS_BITS;
   localparam int SQ_W  = 2 * AXIS_BITS;
   localparam int MUL_W = 2 * AXIS_BITS + 1;
   localparam int P_W   = 2 * MUL_W;
   localparam int DEC_W = 4 * AXIS_BITS + 8;

   state_type        state_ff, state_in;
   logic [N-1:0]     ax_ff, ax_in;
   logic [N-1:0]     bx_ff, bx_in;
   logic [N-1:0]     x_ff, x_in;
   logic [N-1:0]     y_ff, y_in;
   logic [SQ_W-1:0]  a2_ff, a2_in;
   logic [SQ_W-1:0]  b2_ff, b2_in;
   logic [DEC_W-1:0] dec_ff, dec_in;
   logic [P_W-1:0]   tmp_ff, tmp_in;
   logic [P_W-1:0]   prod_ff, prod_in;
   logic             region_two_ff, region_two_in;
   logic             active_ff, active_in;
   logic             neg_ff, neg_in;
   logic [1:0]       k_ff, k_in;

   logic             mul_go;
   logic [MUL_W-1:0] mul_a;
   logic [MUL_W-1:0] mul_b;
   logic [P_W-1:0]   mul_p;

   logic [N-1:0]     a_new;
   logic [N-1:0]     b_new;
   logic [N:0]       y2m1;
   logic [N:0]       xp1;
   logic [N+1:0]     x2p3;
   logic [N:0]       tx;
   logic [N-1:0]     ym1;
   logic [DEC_W-1:0] prod_dec;
   logic             lhs_gt;
   logic [PIX_W-1:0] px;
   logic [PIX_W-1:0] py;
   logic [PIX_W-1:0] pix_x;
   logic [PIX_W-1:0] pix_y;

   // Axes from the request, cut or widened to the axis size
   assign a_new = N'(req_tdata[SEMI_W-1:0]);
   assign b_new = N'(req_tdata[2*SEMI_W-1:SEMI_W]);

   // Small operand terms of the current point
   assign y2m1     = {y_ff, 1'b0} - (N+1)'(1);
   assign xp1      = {1'b0, x_ff} + (N+1)'(1);
   assign x2p3     = {1'b0, x_ff, 1'b0} + (N+2)'(3);
   assign tx       = {x_ff, 1'b1};
   assign ym1      = y_ff - N'(1);
   assign prod_dec = DEC_W'(prod_ff);
   assign lhs_gt   = {1'b0, tmp_ff} > {prod_ff, 1'b0};

   // Shared multiplier
   assign mul_p = P_W'(mul_a) * P_W'(mul_b);

   // Sequencer: next state, multiplier operands and datapath updates
   always_comb begin
      state_in      = state_ff;
      ax_in         = ax_ff;
      bx_in         = bx_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      a2_in         = a2_ff;
      b2_in         = b2_ff;
      dec_in        = dec_ff;
      tmp_in        = tmp_ff;
      region_two_in = region_two_ff;
      active_in     = active_ff;
      neg_in        = neg_ff;
      k_in          = k_ff;
      mul_go        = 1'b0;
      mul_a         = '0;
      mul_b         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tuser == OP_START) begin
                  ax_in    = a_new;
                  bx_in    = b_new;
                  state_in = ST_S_A2;
               end else if (active_ff) begin
                  if (region_two_ff) begin
                     state_in = ST_R2_VERT;
                  end else if (y_ff == '0) begin
                     state_in = ST_R2I_BTX;
                  end else begin
                     state_in = ST_R1_LHS;
                  end
               end
            end
         end
         // Start: a^2, b^2, then 4b^2 + a^2 - 4a^2 b
         ST_S_A2: begin
            mul_go   = 1'b1;
            mul_a    = MUL_W'(ax_ff);
            mul_b    = MUL_W'(ax_ff);
            state_in = ST_S_B2;
         end
         ST_S_B2: begin
            a2_in    = prod_ff[SQ_W-1:0];
            mul_go   = 1'b1;
            mul_a    = MUL_W'(bx_ff);
            mul_b    = MUL_W'(bx_ff);
            state_in = ST_S_AB;
         end
         ST_S_AB: begin
            b2_in    = prod_ff[SQ_W-1:0];
            dec_in   = (prod_dec << 2) + DEC_W'(a2_ff);
            mul_go   = 1'b1;
            mul_a    = MUL_W'(a2_ff);
            mul_b    = MUL_W'(bx_ff);
            state_in = ST_S_FIN;
         end
         ST_S_FIN: begin
            dec_in        = dec_ff - (prod_dec << 2);
            x_in          = '0;
            y_in          = bx_ff;
            region_two_in = 1'b0;
            state_in      = ST_EMIT;
         end
         // Region one test: a^2 (2y-1) > 2 b^2 (x+1)
         ST_R1_LHS: begin
            mul_go   = 1'b1;
            mul_a    = MUL_W'(a2_ff);
            mul_b    = MUL_W'(y2m1);
            state_in = ST_R1_RHS;
         end
         ST_R1_RHS: begin
            tmp_in   = prod_ff;
            mul_go   = 1'b1;
            mul_a    = MUL_W'(b2_ff);
            mul_b    = MUL_W'(xp1);
            state_in = ST_R1_CMP;
         end
         ST_R1_CMP: begin
            if (lhs_gt) begin
               mul_go   = 1'b1;
               mul_a    = MUL_W'(b2_ff);
               mul_b    = MUL_W'(x2p3);
               state_in = ST_R1_INC;
            end else begin
               state_in = ST_R2I_BTX;
            end
         end
         // Region one update: add 4b^2(2x+3), step down if not negative
         ST_R1_INC: begin
            dec_in = dec_ff + (prod_dec << 2);
            if (dec_ff[DEC_W-1]) begin
               x_in     = x_ff + N'(1);
               state_in = ST_EMIT;
            end else begin
               mul_go   = 1'b1;
               mul_a    = MUL_W'(a2_ff);
               mul_b    = MUL_W'(ym1);
               state_in = ST_R1_VERT;
            end
         end
         ST_R1_VERT: begin
            dec_in   = dec_ff - (prod_dec << 3);
            x_in     = x_ff + N'(1);
            y_in     = ym1;
            state_in = ST_EMIT;
         end
         // Region two start: (b tx)^2 + (2a ty)^2 - (2ab)^2
         ST_R2I_BTX: begin
            region_two_in = 1'b1;
            mul_go        = 1'b1;
            mul_a         = MUL_W'(bx_ff);
            mul_b         = MUL_W'(tx);
            state_in      = ST_R2I_SQ1;
         end
         ST_R2I_SQ1: begin
            mul_go   = 1'b1;
            mul_a    = prod_ff[MUL_W-1:0];
            mul_b    = prod_ff[MUL_W-1:0];
            state_in = ST_R2I_ATY;
         end
         ST_R2I_ATY: begin
            dec_in   = prod_dec;
            mul_go   = 1'b1;
            mul_a    = MUL_W'(ax_ff);
            mul_b    = MUL_W'(ym1);
            state_in = ST_R2I_SQ2;
         end
         ST_R2I_SQ2: begin
            mul_go   = 1'b1;
            mul_a    = MUL_W'({prod_ff, 1'b0});
            mul_b    = MUL_W'({prod_ff, 1'b0});
            state_in = ST_R2I_AB;
         end
         ST_R2I_AB: begin
            dec_in   = dec_ff + prod_dec;
            mul_go   = 1'b1;
            mul_a    = MUL_W'(ax_ff);
            mul_b    = MUL_W'(bx_ff);
            state_in = ST_R2I_SQ3;
         end
         ST_R2I_SQ3: begin
            mul_go   = 1'b1;
            mul_a    = MUL_W'({prod_ff, 1'b0});
            mul_b    = MUL_W'({prod_ff, 1'b0});
            state_in = ST_R2I_FIN;
         end
         ST_R2I_FIN: begin
            dec_in   = dec_ff - prod_dec;
            state_in = ST_R2_VERT;
         end
         // Region two: add 4a^2 - 8a^2(y-1), plus 8b^2(x+1) when negative
         ST_R2_VERT: begin
            if (y_ff == '0) begin
               active_in = 1'b0;
               state_in  = ST_IDLE;
            end else begin
               mul_go   = 1'b1;
               mul_a    = MUL_W'(a2_ff);
               mul_b    = MUL_W'(ym1);
               state_in = ST_R2_SUB;
            end
         end
         ST_R2_SUB: begin
            neg_in   = dec_ff[DEC_W-1];
            dec_in   = dec_ff - (prod_dec << 3);
            state_in = ST_R2_ADD;
         end
         ST_R2_ADD: begin
            dec_in = dec_ff + (DEC_W'(a2_ff) << 2);
            if (neg_ff) begin
               mul_go   = 1'b1;
               mul_a    = MUL_W'(b2_ff);
               mul_b    = MUL_W'(xp1);
               state_in = ST_R2_HOR;
            end else begin
               y_in     = ym1;
               state_in = ST_EMIT;
            end
         end
         ST_R2_HOR: begin
            dec_in   = dec_ff + (prod_dec << 3);
            x_in     = x_ff + N'(1);
            y_in     = ym1;
            state_in = ST_EMIT;
         end
         // Offer the four mirrors, close the point on the last one
         ST_EMIT: begin
            if (rsp_tready) begin
               k_in = k_ff + 2'd1;
               if (k_ff == PIX_LAST) begin
                  active_in = (y_ff != '0);
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Load the product only when the multiplier is issued
   assign prod_in = mul_go ? mul_p : prod_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         active_ff     <= 1'b0;
         region_two_ff <= 1'b0;
         k_ff          <= 2'd0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         region_two_ff <= region_two_in;
         k_ff          <= k_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      bx_ff   <= bx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      a2_ff   <= a2_in;
      b2_ff   <= b2_in;
      dec_ff  <= dec_in;
      tmp_ff  <= tmp_in;
      prod_ff <= prod_in;
      neg_ff  <= neg_in;
   end

   // Mirror the point: bit 1 of the index negates x, bit 0 negates y
   assign px    = PIX_W'(x_ff);
   assign py    = PIX_W'(y_ff);
   assign pix_x = k_ff[1] ? (PIX_W'(0) - px) : px;
   assign pix_y = k_ff[0] ? (PIX_W'(0) - py) : py;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_EMIT);
   assign rsp_tdata  = {(RSP_DATA_W - 2*PIX_W)'(0), pix_y, pix_x};
   assign rsp_tlast  = (k_ff == PIX_LAST);
   assign rsp_tuser  = (y_ff == '0);

   // Checks
   `MER_ASSERT_SAME(a_no_overlap, clock, reset, rsp_tvalid, !req_tready,
      "request taken while pixels are pending")
   `MER_ASSERT_NEXT(a_group_ends, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      !rsp_tvalid, "pixel offered after the last of a point")
   `MER_ASSERT_NEXT(a_done_clears, clock, reset,
      rsp_tvalid && rsp_tready && rsp_tlast && rsp_tuser, !active_ff,
      "curve still active after its final point")
   `MER_ASSERT_NEXT(a_axes_hold, clock, reset, !req_tready, $stable(ax_ff) && $stable(bx_ff),
      "axes changed while busy")

endmodule

`default_nettype wire
